@@ hw/rtl/u8d_pkg.sv @@
// shared types and constants for the utf-8 decoder
package u8d_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int COUNT_W = 17;
  localparam int CAUSE_W = 2;

  // result queue depth, in byte results (each holds up to two output items)
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam logic [CP_W-1:0] REPL_CP      = CP_W'(63);
  localparam logic [CP_W-1:0] MIN_CP_2     = CP_W'(32'h80);
  localparam logic [CP_W-1:0] MIN_CP_3     = CP_W'(32'h800);
  localparam logic [CP_W-1:0] MIN_CP_4     = CP_W'(32'h10000);
  localparam logic [CP_W-1:0] SURR_LO      = CP_W'(32'hD800);
  localparam logic [CP_W-1:0] SURR_HI      = CP_W'(32'hDFFF);
  localparam logic [CP_W-1:0] MAX_SCALAR   = CP_W'(32'h10FFFF);

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_REPL = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_EXHAUSTED = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_NUL       = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_INVALID   = 2'd2;

  // register index on the configuration port
  localparam logic REG_COUNT_ONLY = 1'b0;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    kind_t              kind;
    logic [CAUSE_W-1:0] end_cause;
    logic [COUNT_W-1:0] char_count;
    logic               last_of_run;
  } result_t;

  // everything one byte produces
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } pair_t;

endpackage

@@ hw/rtl/utf8_to_utf32_validating_decoder.sv @@
// strict utf-8 to utf-32 decoder: input register, decode step, result queue
// an accepted byte is held in the input register, decoded and written to the queue
// throughput: one byte per cycle while the queue has room; a byte that gives a
//   character and ends a string gives two results, buffered by a 4-entry queue;
//   a full queue holds the input until an entry leaves
// reset (rst, synchronous): clears string state, queue and count_only
// no clearing pass after reset; the block takes bytes from the next cycle
module utf8_to_utf32_validating_decoder
  import u8d_pkg::*;
#(
  parameter int MAX_BUFFER_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CP_W-1:0]    code_point,
  output logic [1:0]         kind,
  output logic [CAUSE_W-1:0] end_cause,
  output logic [COUNT_W-1:0] char_count,
  output logic               last_of_run,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CAP_INT = (MAX_BUFFER_BYTES < 131071) ? MAX_BUFFER_BYTES : 131071;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_INT);

  logic              count_only;
  logic              iq_valid;
  logic [BYTE_W-1:0] iq_byte;
  logic              iq_last;
  logic              q_can_push;
  logic              step;
  pair_t             pair;
  logic              pair_valid;
  result_t           out_res;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COUNT_ONLY) ? {31'b0, count_only} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_only <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_COUNT_ONLY) begin
      count_only <= pwdata[0];
    end
  end

  // input register; decode moves it on whenever the queue has room
  assign step     = iq_valid && q_can_push;
  assign in_ready = !rst && (!iq_valid || q_can_push);

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (in_ready) begin
      iq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      iq_byte <= data_byte;
      iq_last <= last_byte;
    end
  end

  u8d_core #(
    .COUNT_CAP(COUNT_CAP)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (iq_byte),
    .last_in   (iq_last),
    .count_only(count_only),
    .pair      (pair),
    .pair_valid(pair_valid)
  );

  u8d_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .push     (step && pair_valid),
    .push_pair(pair),
    .can_push (q_can_push),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign code_point  = out_res.code_point;
  assign kind        = out_res.kind;
  assign end_cause   = out_res.end_cause;
  assign char_count  = out_res.char_count;
  assign last_of_run = out_res.last_of_run;

endmodule

@@ hw/rtl/u8d_core.sv @@
// decode logic and running string state, one byte per step
module u8d_core
  import u8d_pkg::*;
#(
  parameter logic [COUNT_W-1:0] COUNT_CAP = 17'h10000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              last_in,
  input  logic              count_only,
  output pair_t             pair,
  output logic              pair_valid
);

  logic               discarding, discarding_next;
  logic [1:0]         pend, pend_next;
  logic [1:0]         seqlen, seqlen_next;
  logic [CP_W-1:0]    partial, partial_next;
  logic [COUNT_W-1:0] count, count_next;

  logic [1:0]         lead_len;
  logic [CP_W-1:0]    lead_bits;
  logic [CP_W-1:0]    cp_asm;
  logic               seq_ok;
  logic               bad;
  logic               ch_v;
  logic [CP_W-1:0]    ch_cp;
  kind_t              ch_kind;
  logic               end_v;
  logic [CAUSE_W-1:0] end_cause;
  logic [COUNT_W-1:0] count_inc;
  logic               ch_out;
  result_t            res_ch, res_end;

  always_comb begin
    if (byte_in[7:5] == 3'b110) begin
      lead_len  = 2'd1;
      lead_bits = CP_W'(byte_in[4:0]);
    end else if (byte_in[7:4] == 4'b1110) begin
      lead_len  = 2'd2;
      lead_bits = CP_W'(byte_in[3:0]);
    end else if (byte_in[7:3] == 5'b11110) begin
      lead_len  = 2'd3;
      lead_bits = CP_W'(byte_in[2:0]);
    end else begin
      lead_len  = 2'd0;
      lead_bits = '0;
    end
  end

  assign cp_asm = {partial[CP_W-7:0], byte_in[5:0]};

  always_comb begin
    case (seqlen)
      2'd1:    seq_ok = cp_asm >= MIN_CP_2;
      2'd2:    seq_ok = cp_asm >= MIN_CP_3 && !(cp_asm >= SURR_LO && cp_asm <= SURR_HI);
      default: seq_ok = cp_asm >= MIN_CP_4 && cp_asm <= MAX_SCALAR;
    endcase
  end

  always_comb begin
    discarding_next = discarding;
    pend_next       = pend;
    seqlen_next     = seqlen;
    partial_next    = partial;
    bad             = 1'b0;
    ch_v            = 1'b0;
    ch_cp           = '0;
    ch_kind         = KIND_CHAR;
    end_v           = 1'b0;
    end_cause       = CAUSE_EXHAUSTED;

    if (discarding) begin
      if (last_in) discarding_next = 1'b0;
    end else if (pend == 2'd0) begin
      if (byte_in == '0) begin
        end_v     = 1'b1;
        end_cause = CAUSE_NUL;
      end else if (!byte_in[7]) begin
        ch_v  = 1'b1;
        ch_cp = CP_W'(byte_in);
        end_v = last_in;
      end else if (lead_len != 2'd0) begin
        pend_next    = lead_len;
        seqlen_next  = lead_len;
        partial_next = lead_bits;
        bad          = last_in;
      end else begin
        bad = 1'b1;
      end
    end else if (byte_in[7:6] != 2'b10) begin
      bad = 1'b1;
    end else begin
      partial_next = cp_asm;
      pend_next    = pend - 2'd1;
      if (pend == 2'd1) begin
        seqlen_next  = '0;
        partial_next = '0;
        if (seq_ok) begin
          ch_v  = 1'b1;
          ch_cp = cp_asm;
          end_v = last_in;
        end else begin
          bad = 1'b1;
        end
      end else begin
        bad = last_in;
      end
    end

    if (bad) begin
      ch_v      = 1'b1;
      ch_cp     = REPL_CP;
      ch_kind   = KIND_REPL;
      end_v     = 1'b1;
      end_cause = CAUSE_INVALID;
    end

    count_inc = (ch_v && count < COUNT_CAP) ? count + COUNT_W'(1) : count;

    if (end_v) begin
      count_next      = '0;
      pend_next       = '0;
      seqlen_next     = '0;
      partial_next    = '0;
      discarding_next = !last_in;
    end else begin
      count_next = count_inc;
    end
  end

  assign ch_out = ch_v && !count_only;

  always_comb begin
    res_ch.code_point  = ch_cp;
    res_ch.kind        = ch_kind;
    res_ch.end_cause   = CAUSE_NONE;
    res_ch.char_count  = count_inc;
    res_ch.last_of_run = !end_v;

    res_end.code_point  = '0;
    res_end.kind        = KIND_END;
    res_end.end_cause   = end_cause;
    res_end.char_count  = count_inc;
    res_end.last_of_run = 1'b1;

    pair.first  = ch_out ? res_ch : res_end;
    pair.second = res_end;
    pair.two    = ch_out && end_v;
  end

  assign pair_valid = ch_out || end_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      discarding <= 1'b0;
      pend       <= '0;
      seqlen     <= '0;
      partial    <= '0;
      count      <= '0;
    end else if (step) begin
      discarding <= discarding_next;
      pend       <= pend_next;
      seqlen     <= seqlen_next;
      partial    <= partial_next;
      count      <= count_next;
    end
  end

endmodule

@@ hw/rtl/u8d_resq.sv @@
// small result queue; each entry holds the one or two results of a byte
module u8d_resq
  import u8d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  pair_t   push_pair,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  pair_t               entries [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] cnt;
  logic                sub;
  pair_t               head;
  logic                take;
  logic                pop;

  assign head      = entries[rd_ptr];
  assign out_valid = cnt != '0;
  assign can_push  = cnt != RQ_CNT_W'(RQ_DEPTH);
  assign out_res   = sub ? head.second : head.first;
  assign take      = out_valid && out_ready;
  // entry leaves once its final result is taken
  assign pop       = take && (sub || !head.two);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_pair;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
      sub    <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + RQ_PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      if (push && !pop) begin
        cnt <= cnt + RQ_CNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - RQ_CNT_W'(1);
      end
      if (take) sub <= !pop;
    end
  end

endmodule

@@ hw/rtl/u8d_checker.sv @@
// port-level checks for the decoder, bound to the top level
module u8d_checker
  import u8d_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic [CP_W-1:0]    code_point,
  input logic [1:0]         kind,
  input logic [CAUSE_W-1:0] end_cause,
  input logic               last_of_run
);

  // nothing waits at the output right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result visible after reset");

  // an end result is always the final one for its byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_END) |-> last_of_run)
    else $error("end result not marked last of run");

  a_end_zero_cp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_END) |-> code_point == '0)
    else $error("end result carries a code point");

  // replacement results carry '?' and no cause
  a_repl_cp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_REPL) |-> (code_point == REPL_CP && end_cause == CAUSE_NONE))
    else $error("bad replacement result");

endmodule

bind utf8_to_utf32_validating_decoder u8d_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .code_point (code_point),
  .kind       (kind),
  .end_cause  (end_cause),
  .last_of_run(last_of_run)
);

@@ sim/utf8_to_utf32_validating_decoder_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the strict utf-8 to utf-32 decoder
module utf8_to_utf32_validating_decoder_tb;
  import u8d_pkg::*;

  localparam int MAX_BUF = 65536;
  localparam int COUNT_CAP = (MAX_BUF < 131071) ? MAX_BUF : 131071;
  localparam int UNMAPPED_REG = 1;
  localparam logic [2:0] COUNT_ONLY_ADDR = 3'(4 * REG_COUNT_ONLY);
  localparam logic [2:0] UNMAPPED_ADDR = 3'(4 * UNMAPPED_REG);
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_LEN = 300;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {
    FLAW_NONE,
    FLAW_NUL,
    FLAW_BAD_LEAD,
    FLAW_BAD_CONT,
    FLAW_OVERLONG,
    FLAW_SURROGATE,
    FLAW_TOO_BIG,
    FLAW_TRUNCATED,
    FLAW_NOISE
  } flaw_t;

  typedef struct {
    logic [7:0]         b;
    logic               lst;
    bit                 typed;
    kind_t              k;
    logic [CAUSE_W-1:0] cause;
    logic [CP_W-1:0]    cp;
    logic [COUNT_W-1:0] cnt;
  } script_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [BYTE_W-1:0]  data_byte;
  logic               last_byte;
  logic               out_valid;
  logic               out_ready;
  logic [CP_W-1:0]    code_point;
  logic [1:0]         kind;
  logic [CAUSE_W-1:0] end_cause;
  logic [COUNT_W-1:0] char_count;
  logic               last_of_run;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  utf8_to_utf32_validating_decoder #(
    .MAX_BUFFER_BYTES(MAX_BUF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .code_point(code_point),
    .kind(kind),
    .end_cause(end_cause),
    .char_count(char_count),
    .last_of_run(last_of_run),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // decoder state as predicted
  bit                 mode_count_only = 1'b0;
  bit                 skipping = 1'b0;
  logic [1:0]         owed = 2'd0;
  logic [1:0]         seq_len = 2'd0;
  logic [CP_W-1:0]    acc = '0;
  logic [COUNT_W-1:0] nchars = '0;

  result_t     owed_results[$];
  result_t     byte_results[$];
  logic [7:0]  text_bytes[$];

  int          mismatches = 0;
  int          bytes_sent = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_start = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  // directed strings; typed rows give the last result of that byte
  script_row_t script [0:23] = '{
    '{8'h00, 1'b0, 1'b1, KIND_END,  CAUSE_NUL,       21'd0,       17'd0},
    '{8'hFF, 1'b1, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'h7F, 1'b0, 1'b1, KIND_CHAR, CAUSE_NONE,      21'h7F,      17'd1},
    '{8'hF4, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'h8F, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'hBF, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'hBF, 1'b0, 1'b1, KIND_CHAR, CAUSE_NONE,      21'h10FFFF,  17'd2},
    '{8'hED, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'hA0, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'h80, 1'b0, 1'b1, KIND_END,  CAUSE_INVALID,   21'd0,       17'd3},
    '{8'h41, 1'b1, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'hC0, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'h80, 1'b1, 1'b1, KIND_END,  CAUSE_INVALID,   21'd0,       17'd1},
    '{8'hE2, 1'b1, 1'b1, KIND_END,  CAUSE_INVALID,   21'd0,       17'd1},
    '{8'hF4, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'h90, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'h80, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'h80, 1'b0, 1'b1, KIND_END,  CAUSE_INVALID,   21'd0,       17'd1},
    '{8'h00, 1'b1, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'h80, 1'b0, 1'b1, KIND_END,  CAUSE_INVALID,   21'd0,       17'd1},
    '{8'h20, 1'b1, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'hC3, 1'b0, 1'b0, KIND_CHAR, CAUSE_NONE,      21'd0,       17'd0},
    '{8'h00, 1'b1, 1'b1, KIND_END,  CAUSE_INVALID,   21'd0,       17'd1},
    '{8'h41, 1'b1, 1'b1, KIND_END,  CAUSE_EXHAUSTED, 21'd0,       17'd1}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_char(input logic [CP_W-1:0] cp, input kind_t k);
    result_t r;
    if (nchars < COUNT_W'(COUNT_CAP)) nchars++;
    r = '0;
    r.code_point = cp;
    r.kind = k;
    r.end_cause = CAUSE_NONE;
    r.char_count = nchars;
    if (!mode_count_only) byte_results.push_back(r);
  endfunction

  function automatic void push_end(input logic [CAUSE_W-1:0] cause, input logic lst);
    result_t r;
    r = '0;
    r.kind = KIND_END;
    r.end_cause = cause;
    r.char_count = nchars;
    byte_results.push_back(r);
    nchars = '0;
    owed = 2'd0;
    seq_len = 2'd0;
    acc = '0;
    skipping = !lst;
  endfunction

  function automatic void push_invalid(input logic lst);
    push_char(REPL_CP, KIND_REPL);
    push_end(CAUSE_INVALID, lst);
  endfunction

  // results that one accepted byte should cause, left in byte_results
  function automatic void decode_byte(input logic [7:0] b, input logic lst);
    logic [CP_W-1:0] cp;
    bit              ok;
    result_t         r;
    byte_results.delete();
    if (skipping) begin
      if (lst) skipping = 1'b0;
    end else if (owed == 2'd0) begin
      if (b == 8'h00) begin
        push_end(CAUSE_NUL, lst);
      end else if (b[7] == 1'b0) begin
        push_char(CP_W'(b), KIND_CHAR);
        if (lst) push_end(CAUSE_EXHAUSTED, lst);
      end else begin
        if (b[7:5] == 3'b110) begin
          owed = 2'd1;
          acc = CP_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          owed = 2'd2;
          acc = CP_W'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          owed = 2'd3;
          acc = CP_W'(b[2:0]);
        end else begin
          push_invalid(lst);
        end
        if (owed != 2'd0) begin
          seq_len = owed;
          // buffer ends with continuation bytes still owed
          if (lst) push_invalid(lst);
        end
      end
    end else if (b[7:6] != 2'b10) begin
      push_invalid(lst);
    end else begin
      acc = {acc[CP_W-7:0], b[5:0]};
      owed = owed - 2'd1;
      if (owed == 2'd0) begin
        cp = acc;
        case (seq_len)
          2'd1: ok = cp >= MIN_CP_2;
          2'd2: ok = cp >= MIN_CP_3 && !(cp >= SURR_LO && cp <= SURR_HI);
          default: ok = cp >= MIN_CP_4 && cp <= MAX_SCALAR;
        endcase
        seq_len = 2'd0;
        acc = '0;
        if (ok) begin
          push_char(cp, KIND_CHAR);
          if (lst) push_end(CAUSE_EXHAUSTED, lst);
        end else begin
          push_invalid(lst);
        end
      end else if (lst) begin
        push_invalid(lst);
      end
    end
    if (byte_results.size() != 0) begin
      r = byte_results.pop_back();
      r.last_of_run = 1'b1;
      byte_results.push_back(r);
    end
  endfunction

  function automatic void put_utf8(input logic [CP_W-1:0] cp, input int n);
    case (n)
      1: text_bytes.push_back(cp[7:0]);
      2: begin
        text_bytes.push_back({3'b110, cp[10:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, cp[15:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [CP_W-1:0] pick_scalar(input int n);
    logic [CP_W-1:0] v;
    case (n)
      1: v = CP_W'($urandom_range(1, 32'h7F));
      2: v = CP_W'($urandom_range(32'h80, 32'h7FF));
      3: begin
        do v = CP_W'($urandom_range(32'h800, 32'hFFFF));
        while (v >= SURR_LO && v <= SURR_HI);
      end
      default: v = CP_W'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
    return v;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed = 1'b0,
                           input result_t golden = '0);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, lst);
    if (typed && byte_results.size() != 0) begin
      golden.last_of_run = 1'b1;
      void'(byte_results.pop_back());
      byte_results.push_back(golden);
    end
    foreach (byte_results[i]) owed_results.push_back(byte_results[i]);
    bytes_sent++;
    @(negedge clk);
  endtask

  // one buffer: mostly valid text, sometimes with one flaw and some trailing text
  task automatic send_string();
    int         n;
    flaw_t      flaw;
    logic [7:0] nb;
    text_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      n = $urandom_range(1, 4);
      put_utf8(pick_scalar(n), n);
    end
    flaw = ($urandom_range(0, 99) < 35) ? flaw_t'($urandom_range(1, 8)) : FLAW_NONE;
    case (flaw)
      FLAW_NUL: text_bytes.push_back(8'h00);
      FLAW_BAD_LEAD: begin
        if ($urandom_range(0, 1) == 0) text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      end
      FLAW_BAD_CONT, FLAW_TRUNCATED: begin
        n = $urandom_range(2, 4);
        put_utf8(pick_scalar(n), n);
        repeat ($urandom_range(1, n - 1)) void'(text_bytes.pop_back());
        if (flaw == FLAW_BAD_CONT) begin
          do nb = 8'($urandom_range(0, 255));
          while (nb[7:6] == 2'b10);
          text_bytes.push_back(nb);
        end
      end
      FLAW_OVERLONG: begin
        n = $urandom_range(2, 4);
        put_utf8(CP_W'($urandom_range(0, n == 2 ? 32'h7F : (n == 3 ? 32'h7FF : 32'hFFFF))), n);
      end
      FLAW_SURROGATE: put_utf8(CP_W'($urandom_range(SURR_LO, SURR_HI)), 3);
      FLAW_TOO_BIG: put_utf8(CP_W'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
      FLAW_NOISE: repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    if (flaw != FLAW_NONE && flaw != FLAW_TRUNCATED) begin
      repeat ($urandom_range(0, 3)) begin
        n = $urandom_range(1, 4);
        put_utf8(pick_scalar(n), n);
      end
    end
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  task automatic send_strings(input int n);
    int target;
    target = bytes_sent + n;
    while (bytes_sent < target) send_string();
  endtask

  // wait for the block to drain; bytes with no result may still be in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == COUNT_ONLY_ADDR) mode_count_only = val[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_read_check();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= COUNT_ONLY_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("count_only readback", {31'd0, mode_count_only}, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // result side: random stalls plus a single long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got cp %0h kind %0d cause %0d count %0d",
                 $time, code_point, kind, end_cause, char_count);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        check_field("code_point", 32'(want.code_point), 32'(code_point));
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("end_cause", 32'(want.end_cause), 32'(end_cause));
        check_field("char_count", 32'(want.char_count), 32'(char_count));
        check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
      end
    end
  end

  // no request or result moving for too long means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[utf8_to_utf32_validating_decoder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    result_t golden;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      golden = '0;
      golden.code_point = script[i].cp;
      golden.kind = script[i].k;
      golden.end_cause = script[i].cause;
      golden.char_count = script[i].cnt;
      send_byte(script[i].b, script[i].lst, script[i].typed, golden);
    end

    // count-only; a write past the register list must not touch it
    settle();
    reg_write(COUNT_ONLY_ADDR, 32'd1);
    reg_write(UNMAPPED_ADDR, 32'd0);
    reg_read_check();
    send_strings(60);

    settle();
    reg_write(COUNT_ONLY_ADDR, 32'd0);
    reg_read_check();
    sender_idle_pct = 59;
    send_strings(100);

    settle();
    sender_idle_pct = 0;
    stall_pct = 59;
    send_strings(100);

    settle();
    reg_write(COUNT_ONLY_ADDR, 32'd1);
    sender_idle_pct = 16;
    stall_pct = 16;
    send_strings(80);

    // long hold-off on the result side so the input backs up
    settle();
    reg_write(COUNT_ONLY_ADDR, 32'd0);
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_start = 1'b1;
    send_strings(60);

    settle();
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("[utf8_to_utf32_validating_decoder] OK");
    end else begin
      $display("[utf8_to_utf32_validating_decoder] ERROR");
    end
    $finish;
  end

endmodule
